// File: sv/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants of the Laplacian blur detector.
// ----------------------------------------------------------------------------
package lbd_pkg;

  // field widths
  localparam int PIX_W      = 8;
  localparam int MEAN_W     = 8;
  localparam int VAR_W      = 14;
  localparam int THR_W      = 15;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_THR     = 2'd2;

  // register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [THR_W-1:0]  THR_RST    = 15'd2000;

  // filter and statistics constants
  localparam int MIN_SIZE   = 3;
  localparam int LAP_WEIGHT = 4;
  localparam int K_MEAN     = 8;
  localparam int K_VAR      = 14;
  localparam int QUO_W      = K_VAR + 1;

  localparam logic [MEAN_W-1:0] MEAN_MAX = 8'd255;
  localparam logic [VAR_W-1:0]  VAR_MAX  = 14'd16383;

  typedef enum logic [3:0] {
    ST_PIXEL,
    ST_DRAIN,
    ST_SIZE,
    ST_N2,
    ST_NSQ,
    ST_SS,
    ST_THR,
    ST_MEAN,
    ST_VAR,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_SIZE,
    OP_N2,
    OP_NSQ,
    OP_SS,
    OP_THR,
    OP_MEAN,
    OP_VAR
  } op_t;

  typedef struct packed {
    logic accept;
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic busy;
  } sts_t;

endpackage

// File: sv/lbd_if.sv
// ----------------------------------------------------------------------------
// lbd_if
// Valid/ready channels of the blur detector: pixel in, frame result out.
// ----------------------------------------------------------------------------
interface lbd_pix_if;
  logic                     valid;
  logic                     ready;
  logic [lbd_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lbd_res_if;
  logic                      valid;
  logic                      ready;
  logic [lbd_pkg::MEAN_W-1:0] mean_level;
  logic [lbd_pkg::VAR_W-1:0]  variance;
  logic                      is_blurry;

  modport source (output valid, output mean_level, output variance, output is_blurry,
                  input ready);
  modport sink   (input valid, input mean_level, input variance, input is_blurry,
                  output ready);
endinterface

// File: sv/lbd_ctrl.sv
// ----------------------------------------------------------------------------
// lbd_ctrl
// Frame sequencer: streams pixels, then walks the end-of-frame arithmetic.
// ----------------------------------------------------------------------------
module lbd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lbd_pkg::sts_t   sts,
  output lbd_pkg::cmd_t   cmd
);
  import lbd_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_PIXEL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_PIXEL: if (sts.frame_end) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_SIZE;
      ST_SIZE:  state_nxt = ST_N2;
      ST_N2:    if (!sts.busy) state_nxt = ST_NSQ;
      ST_NSQ:   if (!sts.busy) state_nxt = ST_SS;
      ST_SS:    if (!sts.busy) state_nxt = ST_THR;
      ST_THR:   if (!sts.busy) state_nxt = ST_MEAN;
      ST_MEAN:  if (!sts.busy) state_nxt = ST_VAR;
      ST_VAR:   if (!sts.busy) state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_PIXEL;
      default:  state_nxt = ST_PIXEL;
    endcase
  end

  // outputs; an operation is launched on the edge that enters its state
  always_comb begin
    in_ready   = (state_r == ST_PIXEL);
    out_valid  = (state_r == ST_OUT);
    cmd.accept = in_valid && (state_r == ST_PIXEL);
    cmd.load   = (state_nxt != state_r) &&
                 (state_nxt inside {ST_SIZE, ST_N2, ST_NSQ, ST_SS, ST_THR, ST_MEAN, ST_VAR});
    case (state_nxt)
      ST_N2:   cmd.op = OP_N2;
      ST_NSQ:  cmd.op = OP_NSQ;
      ST_SS:   cmd.op = OP_SS;
      ST_THR:  cmd.op = OP_THR;
      ST_MEAN: cmd.op = OP_MEAN;
      ST_VAR:  cmd.op = OP_VAR;
      default: cmd.op = OP_SIZE;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_frame_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.frame_end |=> (state_r == ST_DRAIN))
    else $error("last pixel did not start the frame drain");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !sts.busy)
    else $error("operation launched while arithmetic unit busy");

endmodule

// File: sv/lbd_dpath.sv
// ----------------------------------------------------------------------------
// lbd_dpath
// Row stores, Laplacian filter, accumulators and a shared shift-add
// multiplier / restoring divider for the end-of-frame statistics.
// ----------------------------------------------------------------------------
module lbd_dpath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lbd_pkg::PIX_W-1:0]      pixel,
  input  logic                           cfg_we,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  lbd_pkg::cmd_t                  cmd,
  output lbd_pkg::sts_t                  sts,
  output logic [lbd_pkg::MEAN_W-1:0]     mean_level,
  output logic [lbd_pkg::VAR_W-1:0]      variance,
  output logic                           is_blurry
);
  import lbd_pkg::*;

  localparam int NMAX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int N_W   = $clog2(NMAX) + 1;
  localparam int N2_W  = 2 * N_W;
  localparam int SUM_W = N_W + 9;
  localparam int SQ_W  = N_W + 17;
  localparam int P_W   = 2 * N_W + 18;
  localparam int MB_W  = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int CNT_W = $clog2(MB_W + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WE_W  = $clog2(MAX_WIDTH + 1);
  localparam int HE_W  = $clog2(MAX_HEIGHT + 1);

  // configuration registers
  logic [SIZE_W-1:0] cfg_w_r, cfg_h_r;
  logic [THR_W-1:0]  cfg_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= WIDTH_RST;
      cfg_h_r   <= HEIGHT_RST;
      cfg_thr_r <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FRAME_WIDTH:  cfg_w_r   <= cfg_data[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: cfg_h_r   <= cfg_data[SIZE_W-1:0];
        CFG_BLUR_THR:     cfg_thr_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size in force, limited to the supported range
  logic [WE_W-1:0] w_eff;
  logic [HE_W-1:0] h_eff;

  always_comb begin
    if (cfg_w_r < SIZE_W'(MIN_SIZE)) begin
      w_eff = WE_W'(MIN_SIZE);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(cfg_w_r);
    end
    if (cfg_h_r < SIZE_W'(MIN_SIZE)) begin
      h_eff = HE_W'(MIN_SIZE);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_eff = HE_W'(MAX_HEIGHT);
    end else begin
      h_eff = HE_W'(cfg_h_r);
    end
  end

  // position and neighborhood; row data is prefetched for the next column
  logic [COL_W-1:0] col_r, col_nxt, rgt_addr;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [PIX_W-1:0] cen_r, up_r, rgt_r, left_r;
  logic [PIX_W-1:0] ra_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rb_mem [MAX_WIDTH];
  logic             col_end, row_end, lap_en, pix_en, frame_end;
  logic [9:0]       lap_pos, lap_neg, lap_diff;
  logic [PIX_W-1:0] lap_val;

  always_comb begin
    col_end   = (32'(col_r) + 1 >= 32'(w_eff));
    row_end   = (32'(row_r) + 1 >= 32'(h_eff));
    lap_en    = (32'(row_r) >= 2) && (col_r != '0) && !col_end;
    pix_en    = (row_r == '0) || row_end || (col_r == '0) || col_end;
    frame_end = cmd.accept && col_end && row_end;
    col_nxt   = col_end ? '0 : COL_W'(32'(col_r) + 1);
    rgt_addr  = (32'(col_nxt) == MAX_WIDTH - 1) ? '0 : COL_W'(32'(col_nxt) + 1);
    if (col_end) begin
      row_nxt = row_end ? '0 : ROW_W'(32'(row_r) + 1);
    end else begin
      row_nxt = row_r;
    end
  end

  // four-neighbor Laplacian, clamped to the pixel range
  always_comb begin
    lap_pos  = 10'(up_r) + 10'(pixel) + 10'(left_r) + 10'(rgt_r);
    lap_neg  = 10'(cen_r) * 10'(LAP_WEIGHT);
    lap_diff = lap_pos - lap_neg;
    if (lap_neg >= lap_pos) begin
      lap_val = '0;
    end else if (lap_diff > 10'(MEAN_MAX)) begin
      lap_val = MEAN_MAX;
    end else begin
      lap_val = lap_diff[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (cmd.accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= cen_r;
    end
  end

  // row stores: one write and the reads for the next column
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ra_mem[col_r] <= pixel;
      rb_mem[col_r] <= cen_r;
      cen_r         <= ra_mem[col_nxt];
      rgt_r         <= ra_mem[rgt_addr];
      up_r          <= rb_mem[col_nxt];
    end
  end

  // filter stage register
  logic             s1_vld_r, s1_last_r, lap_en_r, pix_en_r;
  logic [PIX_W-1:0] lap_r, pix_r;
  logic [WE_W-1:0]  w_cap_r;
  logic [HE_W-1:0]  h_cap_r;
  logic [THR_W-1:0] thr_cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
    end else begin
      s1_vld_r  <= cmd.accept;
      s1_last_r <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lap_r    <= lap_val;
      lap_en_r <= lap_en;
      pix_r    <= pixel;
      pix_en_r <= pix_en;
    end
    if (frame_end) begin
      w_cap_r   <= w_eff;
      h_cap_r   <= h_eff;
      thr_cap_r <= cfg_thr_r;
    end
  end

  // accumulators; snapshot and clear at the end of a frame
  logic [SUM_W-1:0] sum_r, sum_add, sum_cap_r;
  logic [SQ_W-1:0]  sq_r, sq_add, sq_cap_r;
  logic [PIX_W-1:0] lap_term, pix_term;

  always_comb begin
    lap_term = lap_en_r ? lap_r : '0;
    pix_term = pix_en_r ? pix_r : '0;
    sum_add  = sum_r + SUM_W'(lap_term) + SUM_W'(pix_term);
    sq_add   = sq_r + SQ_W'(lap_term * lap_term) + SQ_W'(pix_term * pix_term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sq_r  <= '0;
    end else if (s1_vld_r) begin
      if (s1_last_r) begin
        sum_r <= '0;
        sq_r  <= '0;
      end else begin
        sum_r <= sum_add;
        sq_r  <= sq_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && s1_last_r) begin
      sum_cap_r <= sum_add;
      sq_cap_r  <= sq_add;
    end
  end

  // shared arithmetic unit: shift-add multiply or restoring divide
  logic             busy_r;
  op_t              op_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   acc_r, opa_r, acc_step, opa_step;
  logic [MB_W-1:0]  opb_r, opb_step;
  logic [QUO_W-1:0] quo_r, quo_step;
  logic             is_mul, div_ge, last_step;
  logic [N_W-1:0]   n_r;
  logic [N2_W-1:0]  n2_r;
  logic [P_W-1:0]   nsq_r, d_r;
  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;
  logic              blurry_r;

  always_comb begin
    is_mul    = op_r inside {OP_N2, OP_NSQ, OP_SS, OP_THR};
    div_ge    = (acc_r >= opa_r);
    last_step = busy_r && (cnt_r == CNT_W'(1));
    opb_step  = opb_r >> 1;
    quo_step  = {quo_r[QUO_W-2:0], div_ge};
    if (is_mul) begin
      acc_step = opb_r[0] ? acc_r + opa_r : acc_r;
      opa_step = opa_r << 1;
    end else begin
      acc_step = div_ge ? acc_r - opa_r : acc_r;
      opa_step = opa_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.load) begin
      busy_r <= (cmd.op != OP_SIZE);
    end else if (last_step) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= cmd.op;
      quo_r <= '0;
      acc_r <= '0;
      cnt_r <= CNT_W'(MB_W);
      case (cmd.op)
        OP_SIZE: begin
          n_r <= N_W'(w_cap_r) * N_W'(h_cap_r);
        end
        OP_N2: begin
          opa_r <= P_W'(n_r);
          opb_r <= MB_W'(n_r);
        end
        OP_NSQ: begin
          opa_r <= P_W'(sq_cap_r);
          opb_r <= MB_W'(n_r);
        end
        OP_SS: begin
          opa_r <= P_W'(sum_cap_r);
          opb_r <= MB_W'(sum_cap_r);
        end
        OP_THR: begin
          opa_r <= P_W'(n2_r);
          opb_r <= MB_W'(thr_cap_r);
        end
        OP_MEAN: begin
          acc_r <= P_W'(sum_cap_r);
          opa_r <= P_W'(n_r) << K_MEAN;
          cnt_r <= CNT_W'(K_MEAN + 1);
        end
        OP_VAR: begin
          acc_r <= d_r;
          opa_r <= P_W'(n2_r) << K_VAR;
          cnt_r <= CNT_W'(K_VAR + 1);
        end
        default: ;
      endcase
    end else if (busy_r) begin
      acc_r <= acc_step;
      opa_r <= opa_step;
      opb_r <= opb_step;
      quo_r <= quo_step;
      cnt_r <= cnt_r - CNT_W'(1);
      // results land on the final step
      if (last_step) begin
        case (op_r)
          OP_N2:  n2_r  <= N2_W'(acc_step);
          OP_NSQ: nsq_r <= acc_step;
          OP_SS:  d_r   <= (nsq_r > acc_step) ? nsq_r - acc_step : '0;
          OP_THR: blurry_r <= (d_r <= acc_step);
          OP_MEAN: mean_r <= quo_step[K_MEAN] ? MEAN_MAX : quo_step[MEAN_W-1:0];
          OP_VAR:  var_r  <= quo_step[K_VAR] ? VAR_MAX : quo_step[VAR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sts.frame_end = frame_end;
    sts.busy      = busy_r;
    mean_level    = mean_r;
    variance      = var_r;
    is_blurry     = blurry_r;
  end

  a_no_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !busy_r)
    else $error("pixel item accepted during end-of-frame arithmetic");

  a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
    last_step |=> !busy_r)
    else $error("arithmetic unit ran past its step count");

  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_last_r) |=> (sum_r == '0 && sq_r == '0))
    else $error("accumulators not cleared after last pixel");

endmodule

// File: sv/laplacian_blur_detector.sv
// ----------------------------------------------------------------------------
// laplacian_blur_detector
// Four-neighbor Laplacian over a raster grayscale frame with per-frame
// mean, variance and blurry flag of the filtered pixels.
//
//   port     dir   handshake      payload
//   in_pix   in    valid/ready    pixel[7:0]
//   out_res  out   valid/ready    mean_level[7:0], variance[13:0], is_blurry
//   cfg_*    in    cfg_we         cfg_idx[1:0], cfg_data[14:0]
//
// One pixel item per clock within a frame; row stores are two memories,
// one of them read at two addresses, so the filter keeps pace with the input.
// After the last pixel of a frame the input is held off while the
// serial multiplier and divider form the statistics; then the result
// waits in its register until taken.
// Reset is synchronous: position, accumulators and registers are cleared
// (640 x 480, threshold 2000); row stores are not cleared.
// ----------------------------------------------------------------------------
module laplacian_blur_detector #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lbd_pix_if.sink                        in_pix,
  lbd_res_if.source                      out_res,
  input  logic                           cfg_we,
  input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // frame sequencer
  lbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // filter, accumulators and statistics arithmetic
  lbd_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .pixel      (in_pix.pixel),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .mean_level (out_res.mean_level),
    .variance   (out_res.variance),
    .is_blurry  (out_res.is_blurry)
  );

endmodule

// File: bench/tb_laplacian_blur_detector.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_laplacian_blur_detector
// Self-checking bench for the Laplacian blur detector. Frames are streamed
// pixel by pixel; a local model of the row stores, the clamped Laplacian and
// the frame statistics predicts all results but two fixed ones, compared
// field by field. Directed frames cover flat black and white, size clamping,
// the unused register index and a resize in mid-frame; then the two largest
// shapes, then random frames under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_laplacian_blur_detector;
  import lbd_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int MULT_BITS      = $clog2(MAX_W * MAX_H) + 10;
  localparam int SETTLE_CYCLES  = 4 * MULT_BITS + 27 + 50;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RAND_ITEMS     = 1900;
  localparam int MIN_RAND_FRAMES = 40;

  // register index outside the list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [2:0] {
    PAT_FLAT,
    PAT_NOISE,
    PAT_RAMP,
    PAT_CHECKER,
    PAT_SPECK
  } pattern_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_level;
    logic [VAR_W-1:0]  variance;
    logic              is_blurry;
  } stats_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] width_data;
    logic [CFG_DATA_W-1:0] height_data;
    logic [CFG_DATA_W-1:0] thr_data;
    logic                  spare_write;
    pattern_e              kind;
    logic [PIX_W-1:0]      level;
    int                    pause_at;
    logic [CFG_DATA_W-1:0] pause_width;
    logic                  fixed;
    stats_t                want;
  } frame_case_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbd_pix_if pix_ch ();
  lbd_res_if res_ch ();

  laplacian_blur_detector #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch.sink),
    .out_res (res_ch.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // model state: registers, row stores, position and accumulators
  logic [SIZE_W-1:0] reg_width  = WIDTH_RST;
  logic [SIZE_W-1:0] reg_height = HEIGHT_RST;
  logic [THR_W-1:0]  reg_thr    = THR_RST;
  bit [PIX_W-1:0]    line_prev  [MAX_W];
  bit [PIX_W-1:0]    line_prev2 [MAX_W];
  int                col_pos    = 0;
  int                row_pos    = 0;
  int                left_pix   = 0;
  longint unsigned   value_sum  = 0;
  longint unsigned   square_sum = 0;

  stats_t stats_due [$];
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     errors         = 0;
  int     frames_sent    = 0;
  int     frames_checked = 0;
  int     pixels_sent    = 0;
  int     resizes        = 0;
  int     idle_cycles    = 0;

  frame_case_t dir_cases [3];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // advance the model by one pixel; returns 1 with the frame result at the last pixel
  function automatic bit step_frame_stats(input logic [PIX_W-1:0] pix, output stats_t res);
    int              w, h, c, r, pv, ctr, up, rt, lap;
    longint unsigned n, n2, a, b, d, q, m;
    w   = clamp_size(reg_width, MAX_W);
    h   = clamp_size(reg_height, MAX_H);
    c   = col_pos % MAX_W;
    r   = row_pos;
    pv  = int'(pix);
    ctr = int'(line_prev[c]);
    up  = int'(line_prev2[c]);
    res = '0;
    step_frame_stats = 1'b0;
    // interior pixel one row up gets the clamped Laplacian
    if (r >= 2 && c >= 1 && c + 1 < w) begin
      rt  = int'(line_prev[(c + 1) % MAX_W]);
      lap = up + pv + left_pix + rt - LAP_WEIGHT * ctr;
      if (lap < 0) lap = 0;
      if (lap > 255) lap = 255;
      value_sum  += longint'(lap);
      square_sum += longint'(lap * lap);
    end
    // border pixels pass unchanged
    if (r == 0 || r + 1 >= h || c == 0 || c + 1 >= w) begin
      value_sum  += longint'(pv);
      square_sum += longint'(pv * pv);
    end
    left_pix      = ctr;
    line_prev2[c] = ctr[PIX_W-1:0];
    line_prev[c]  = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      if (r + 1 >= h) begin
        // frame statistics
        n  = w * h;
        n2 = n * n;
        a  = n * square_sum;
        b  = value_sum * value_sum;
        d  = (a > b) ? a - b : 0;
        q  = d / n2;
        m  = value_sum / n;
        res.mean_level = (m > 255) ? MEAN_MAX : m[MEAN_W-1:0];
        res.variance   = (q > 16383) ? VAR_MAX : q[VAR_W-1:0];
        res.is_blurry  = (d <= longint'(reg_thr) * n2);
        step_frame_stats = 1'b1;
        row_pos    = 0;
        value_sum  = 0;
        square_sum = 0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic [PIX_W-1:0] pattern_pixel(input pattern_e kind,
                                                     input logic [PIX_W-1:0] level,
                                                     input int r, input int c);
    case (kind)
      PAT_FLAT:    return level;
      PAT_NOISE:   return PIX_W'($urandom_range(0, 255));
      PAT_RAMP:    return PIX_W'(level + 5 * c + 3 * r + $urandom_range(0, 2));
      PAT_CHECKER: return ((r + c) % 2 != 0) ? 8'hff : level;
      default:     return ($urandom_range(0, 9) == 0) ? ~level : level;
    endcase
  endfunction

  // size register data: mostly small, sometimes below the minimum, junk upper bits
  function automatic logic [CFG_DATA_W-1:0] rand_size_data(input int hi);
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    if ($urandom_range(0, 99) < 8) v[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 2));
    else v[SIZE_W-1:0] = SIZE_W'($urandom_range(MIN_SIZE, hi));
    if ($urandom_range(0, 99) < 25) v[CFG_DATA_W-1:SIZE_W] = 4'($urandom_range(0, 15));
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_thr();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 15'd16384;
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(0, 400));
      default: return CFG_DATA_W'($urandom_range(0, 16384));
    endcase
  endfunction

  task automatic set_idle(input idle_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      default:   begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
  endtask

  // one register write, mirrored into the model copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  reg_width  = data[SIZE_W-1:0];
      CFG_FRAME_HEIGHT: reg_height = data[SIZE_W-1:0];
      CFG_BLUR_THR:     reg_thr    = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] w_data, input logic [CFG_DATA_W-1:0] h_data,
                          input logic [CFG_DATA_W-1:0] thr_data, input logic spare);
    write_reg(CFG_FRAME_WIDTH, w_data);
    write_reg(CFG_FRAME_HEIGHT, h_data);
    if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_BLUR_THR, thr_data);
    cfg_we <= 1'b0;
  endtask

  // hold the sender until every frame result is in and the block has settled
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    do @(posedge clk); while (!pix_ch.ready);
    pixels_sent++;
  endtask

  // stream pixels until the model sees the frame end; optional resize part way
  task automatic send_frame(input pattern_e kind, input logic [PIX_W-1:0] level,
                            input int pause_at, input logic [CFG_DATA_W-1:0] pause_w,
                            input logic [CFG_DATA_W-1:0] pause_h,
                            input logic [CFG_DATA_W-1:0] pause_thr,
                            input logic fixed, input stats_t want);
    int               sent;
    bit               done;
    stats_t           got;
    logic [PIX_W-1:0] p;
    sent = 0;
    done = 1'b0;
    while (!done) begin
      if (pause_at != 0 && sent == pause_at) begin
        wait_drained();
        set_regs(pause_w, pause_h, pause_thr, 1'b0);
        resizes++;
      end
      p = pattern_pixel(kind, level, row_pos, col_pos);
      push_pixel(p);
      sent++;
      done = step_frame_stats(p, got);
      if (done) stats_due.push_back(fixed ? want : got);
    end
    frames_sent++;
  endtask

  // receiver: random stalls and result checking
  initial begin
    stats_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        if (stats_due.size() == 0) begin
          $error("frame result with no frame pending");
          errors++;
        end else begin
          want = stats_due.pop_front();
          if (res_ch.mean_level !== want.mean_level) begin
            $error("mean_level: expected %0d, got %0d", want.mean_level, res_ch.mean_level);
            errors++;
          end
          if (res_ch.variance !== want.variance) begin
            $error("variance: expected %0d, got %0d", want.variance, res_ch.variance);
            errors++;
          end
          if (res_ch.is_blurry !== want.is_blurry) begin
            $error("is_blurry: expected %0d, got %0d", want.is_blurry, res_ch.is_blurry);
            errors++;
          end
          frames_checked++;
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any item or register write
  initial begin
    forever begin
      @(posedge clk);
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("laplacian_blur_detector regression: fail");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    int                    rand_base;
    int                    rand_frames;
    int                    cur_w;
    logic [CFG_DATA_W-1:0] pw, ph;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_FRAME_WIDTH;
    cfg_data     <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;

    // directed frames: black, clamped white with spare write, resize in mid-frame
    dir_cases[0] = '{15'd3, 15'd3, 15'd0, 1'b0, PAT_FLAT, 8'd0, 0, 15'd0,
                     1'b1, '{8'd0, 14'd0, 1'b1}};
    dir_cases[1] = '{15'h7800, 15'd2, 15'd16384, 1'b1, PAT_FLAT, 8'd255, 0, 15'd0,
                     1'b1, '{8'd226, 14'd6422, 1'b1}};
    dir_cases[2] = '{15'd4, 15'd3, 15'h7fff, 1'b0, PAT_CHECKER, 8'd0, 6, 15'd3,
                     1'b0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_NONE);

    foreach (dir_cases[i]) begin
      wait_drained();
      set_regs(dir_cases[i].width_data, dir_cases[i].height_data, dir_cases[i].thr_data,
               dir_cases[i].spare_write);
      send_frame(dir_cases[i].kind, dir_cases[i].level, dir_cases[i].pause_at,
                 dir_cases[i].pause_width, dir_cases[i].height_data, dir_cases[i].thr_data,
                 dir_cases[i].fixed, dir_cases[i].want);
    end

    // widest and tallest frames, sizes given past the maximum
    set_idle(IDLE_BOTH);
    wait_drained();
    set_regs(15'd2047, 15'd3, rand_thr(), 1'b0);
    send_frame(PAT_NOISE, 8'd0, 0, '0, '0, '0, 1'b0, '0);
    wait_drained();
    set_regs(15'd3, 15'd1025, rand_thr(), 1'b0);
    send_frame(PAT_RAMP, PIX_W'($urandom_range(0, 255)), 0, '0, '0, '0, 1'b0, '0);

    // random frames, idling mode changes by quarter of the pixel budget
    rand_base   = pixels_sent;
    rand_frames = 0;
    while (pixels_sent - rand_base < RAND_ITEMS || rand_frames < MIN_RAND_FRAMES) begin
      set_idle(idle_e'(((pixels_sent - rand_base) * 4 / RAND_ITEMS) % 4));
      if (rand_frames == 0 || $urandom_range(0, 99) < 50) begin
        wait_drained();
        set_regs(rand_size_data(($urandom_range(0, 99) < 5) ? 24 : 10), rand_size_data(8),
                 rand_thr(), ($urandom_range(0, 99) < 10));
      end
      // mid-frame resize: width only shrinks, height anything
      cur_w = clamp_size(reg_width, MAX_W);
      pw    = CFG_DATA_W'($urandom_range(MIN_SIZE, cur_w));
      ph    = rand_size_data(8);
      send_frame(pattern_e'($urandom_range(0, 4)), PIX_W'($urandom_range(0, 255)),
                 ($urandom_range(0, 99) < 15) ? $urandom_range(1, 20) : 0,
                 pw, ph, rand_thr(), 1'b0, '0);
      rand_frames++;
    end

    wait_drained();
    $display("checked %0d of %0d frame results over %0d pixels, %0d mid-frame resizes",
             frames_checked, frames_sent, pixels_sent, resizes);
    $display("sizes from clamped 3x3 to 1024 wide and tall, thresholds 0 to 32767");
    if (errors == 0) begin
      $display("laplacian_blur_detector regression: pass");
    end else begin
      $display("laplacian_blur_detector regression: fail");
    end
    $finish;
  end

endmodule

// File: laplacian_blur_detector.f
sv/lbd_pkg.sv
sv/lbd_if.sv
sv/lbd_ctrl.sv
sv/lbd_dpath.sv
sv/laplacian_blur_detector.sv
bench/tb_laplacian_blur_detector.sv
